// File: rtl/fca_pkg.sv
// ---------------------------------------------------------------------------
// fca_pkg
// Types, codes and fixed field widths of the chain allocator.
// ---------------------------------------------------------------------------
package fca_pkg;

  // fixed field widths
  localparam int OP_W   = 3;
  localparam int BLK_W  = 11;
  localparam int LEN_W  = 12;
  localparam int STAT_W = 2;
  localparam int KIND_W = 2;
  localparam int ENT_W  = 12;

  // table entry codes
  localparam logic [ENT_W-1:0] END_MARK  = 12'hFFF;
  localparam logic [ENT_W-1:0] FREE_MARK = 12'h000;

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_COUNT  = 3'd2,
    OP_READ   = 3'd3,
    OP_FORMAT = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_BOUND   = 2'd2
  } status_e;

  // entry kind for read
  typedef enum logic [KIND_W-1:0] {
    KIND_INDEX = 2'd0,
    KIND_END   = 2'd1,
    KIND_FREE  = 2'd2
  } kind_e;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LINK,
    S_LINK_END,
    S_WALK,
    S_FREE,
    S_READ,
    S_DONE
  } state_e;

  // one result beat
  typedef struct packed {
    status_e          status;
    logic [BLK_W-1:0] first_block;
    logic [LEN_W-1:0] length;
    kind_e            kind;
  } res_t;

endpackage

// File: rtl/fca_mem.sv
// ---------------------------------------------------------------------------
// fca_mem
// Table storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module fca_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [fca_pkg::ENT_W-1:0]  wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [fca_pkg::ENT_W-1:0]  rdata_o
);
  import fca_pkg::*;

  logic [ENT_W-1:0] mem_q [DEPTH];
  logic [ENT_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fca_ctrl.sv
// ---------------------------------------------------------------------------
// fca_ctrl
// Sequencer: table sweeps, allocation scans, chain walks and entry reads.
// ---------------------------------------------------------------------------
module fca_ctrl #(
  parameter int ENTRIES     = 2048,
  parameter int ROOT_INDEX  = 0,
  parameter int TABLE_INDEX = 1,
  parameter int AW          = $clog2(ENTRIES)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request side
  input  logic                       req_valid_i,
  output logic                       req_stall_o,
  input  logic [fca_pkg::OP_W-1:0]   op_i,
  input  logic [fca_pkg::BLK_W-1:0]  block_i,
  input  logic [fca_pkg::LEN_W-1:0]  amount_i,
  // result side
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output fca_pkg::res_t              res_o,
  // table port
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [fca_pkg::ENT_W-1:0]  mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [fca_pkg::ENT_W-1:0]  mem_rdata_i
);
  import fca_pkg::*;

  localparam int IW = AW + 1;
  localparam int CW = $clog2(ENTRIES + 2);
  // the index equal to the end mark is never handed out
  localparam int SCAN_LIM = (ENTRIES > int'(END_MARK)) ? int'(END_MARK) : ENTRIES;
  localparam logic [ENT_W:0] ENTRIES_X = (ENT_W + 1)'(ENTRIES);

  state_e             state_q, state_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [BLK_W-1:0]   block_q, block_d;
  logic [LEN_W-1:0]   amount_q, amount_d;
  logic               fmt_q, fmt_d;
  logic [IW-1:0]      iss_q, iss_d;
  logic [AW-1:0]      ridx_q, ridx_d;
  logic               rv_q, rv_d;
  logic [LEN_W-1:0]   found_q, found_d;
  logic [AW-1:0]      prev_q, prev_d;
  logic [AW-1:0]      first_q, first_d;
  logic [AW-1:0]      cur_q, cur_d;
  logic [CW-1:0]      n_q, n_d;
  res_t               res_q, res_d;

  logic               accept;
  logic               blk_out;
  logic               ent_out;
  logic               sweep_hit;

  assign accept    = req_valid_i && !req_stall_o;
  assign blk_out   = {2'b00, block_i} >= ENTRIES_X;
  assign ent_out   = {1'b0, mem_rdata_i} >= ENTRIES_X;
  assign sweep_hit = fmt_q && ((ENT_W'(iss_q[AW-1:0]) == ENT_W'(ROOT_INDEX)) ||
                               (ENT_W'(iss_q[AW-1:0]) == ENT_W'(TABLE_INDEX)));

  assign req_stall_o = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      fmt_q   <= 1'b0;
      iss_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fmt_q   <= fmt_d;
      iss_q   <= iss_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    block_q  <= block_d;
    amount_q <= amount_d;
    ridx_q   <= ridx_d;
    found_q  <= found_d;
    prev_q   <= prev_d;
    first_q  <= first_d;
    cur_q    <= cur_d;
    n_q      <= n_d;
    res_q    <= res_d;
  end

  // next state, table accesses and results
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    block_d     = block_q;
    amount_d    = amount_q;
    fmt_d       = fmt_q;
    iss_d       = iss_q;
    ridx_d      = ridx_q;
    rv_d        = 1'b0;
    found_d     = found_q;
    prev_d      = prev_q;
    first_d     = first_q;
    cur_d       = cur_q;
    n_d         = n_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_wdata_o = FREE_MARK;
    mem_re_o    = 1'b0;
    mem_raddr_o = cur_q;

    unique case (state_q)
      // sweep the whole table, after reset and on format
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = iss_q[AW-1:0];
        mem_wdata_o = sweep_hit ? END_MARK : FREE_MARK;
        iss_d       = iss_q + IW'(1);
        if (iss_q[AW-1:0] == AW'(ENTRIES - 1)) begin
          iss_d = '0;
          fmt_d = 1'b0;
          if (fmt_q) begin
            res_d   = '{status: STAT_OK, first_block: '0, length: '0, kind: KIND_INDEX};
            state_d = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      // take a request and dispatch
      S_IDLE: begin
        res_d = '{status: STAT_OK, first_block: '0, length: '0, kind: KIND_INDEX};
        if (accept) begin
          op_d        = op_i;
          block_d     = block_i;
          amount_d    = amount_i;
          cur_d       = AW'(block_i);
          n_d         = CW'(1);
          found_d     = '0;
          iss_d       = '0;
          mem_raddr_o = AW'(block_i);
          unique case (op_i)
            OP_ALLOC: begin
              if (amount_i == '0) begin
                res_d.status = STAT_NOSPACE;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_FREE, OP_COUNT: begin
              if (blk_out) begin
                res_d.status = STAT_BOUND;
                state_d      = S_DONE;
              end else begin
                mem_re_o = 1'b1;
                state_d  = S_WALK;
              end
            end
            OP_READ: begin
              if (blk_out) begin
                res_d.status = STAT_BOUND;
                state_d      = S_DONE;
              end else begin
                mem_re_o = 1'b1;
                state_d  = S_READ;
              end
            end
            OP_FORMAT: begin
              fmt_d   = 1'b1;
              state_d = S_CLEAR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // first pass: count free entries from the bottom
      S_SCAN: begin
        if (iss_q < IW'(SCAN_LIM)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = iss_q[AW-1:0];
          ridx_d      = iss_q[AW-1:0];
          rv_d        = 1'b1;
          iss_d       = iss_q + IW'(1);
        end
        if (rv_q) begin
          if ((mem_rdata_i == FREE_MARK) && (found_q + LEN_W'(1) == amount_q)) begin
            iss_d   = '0;
            rv_d    = 1'b0;
            found_d = '0;
            state_d = S_LINK;
          end else begin
            if (mem_rdata_i == FREE_MARK) begin
              found_d = found_q + LEN_W'(1);
            end
            if (ridx_q == AW'(SCAN_LIM - 1)) begin
              res_d.status = STAT_NOSPACE;
              state_d      = S_DONE;
            end
          end
        end
      end

      // second pass: link each free entry to the next one found
      S_LINK: begin
        if (iss_q < IW'(SCAN_LIM)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = iss_q[AW-1:0];
          ridx_d      = iss_q[AW-1:0];
          rv_d        = 1'b1;
          iss_d       = iss_q + IW'(1);
        end
        if (rv_q && (mem_rdata_i == FREE_MARK)) begin
          if (found_q == '0) begin
            first_d = ridx_q;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = prev_q;
            mem_wdata_o = ENT_W'(ridx_q);
          end
          prev_d  = ridx_q;
          found_d = found_q + LEN_W'(1);
          if (found_q + LEN_W'(1) == amount_q) begin
            rv_d    = 1'b0;
            state_d = S_LINK_END;
          end
        end
      end

      // close the new chain
      S_LINK_END: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = prev_q;
        mem_wdata_o = END_MARK;
        res_d       = '{status: STAT_OK, first_block: BLK_W'(first_q),
                        length: amount_q, kind: KIND_INDEX};
        state_d     = S_DONE;
      end

      // follow a chain one entry a cycle
      S_WALK: begin
        if (mem_rdata_i == END_MARK) begin
          if (op_q == OP_FREE) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AW'(block_q);
            cur_d       = AW'(block_q);
            state_d     = S_FREE;
          end else begin
            res_d.length = LEN_W'(n_q);
            state_d      = S_DONE;
          end
        end else if (ent_out || (n_q == CW'(ENTRIES))) begin
          res_d.status = STAT_BOUND;
          state_d      = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = mem_rdata_i[AW-1:0];
          cur_d       = mem_rdata_i[AW-1:0];
          n_d         = n_q + CW'(1);
        end
      end

      // walk the checked chain again, clearing each entry
      S_FREE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cur_q;
        mem_wdata_o = FREE_MARK;
        if (mem_rdata_i == END_MARK) begin
          res_d.length = LEN_W'(n_q);
          state_d      = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = mem_rdata_i[AW-1:0];
          cur_d       = mem_rdata_i[AW-1:0];
        end
      end

      // classify one entry
      S_READ: begin
        priority if (mem_rdata_i == END_MARK) begin
          res_d.kind = KIND_END;
        end else if (mem_rdata_i == FREE_MARK) begin
          res_d.kind = KIND_FREE;
        end else begin
          res_d.first_block = mem_rdata_i[BLK_W-1:0];
        end
        state_d = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/fat_chain_allocator.sv
// ---------------------------------------------------------------------------
// fat_chain_allocator
// File allocation table engine: allocate, free and count chains, read entries,
// and format the table held in one on-chip memory.
// ---------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  request   in         in_valid_i / in_stall_o  op_i, block_i, amount_i
//  result    out        out_valid_o / out_stall_i status_o, first_block_o,
//                                                 length_o, entry_kind_o
//
//  allocate runs a counting scan and a linking scan, each reading one table
//  entry a cycle through the memory port; count walks the chain, free walks
//  it twice, read fetches one entry and format sweeps the whole table.
//  after reset a clearing pass over the whole table runs with in_stall_o high.
//  a held result sits in the output register; the next request is taken
//  meanwhile and waits only when its own result is ready.
// ---------------------------------------------------------------------------
module fat_chain_allocator #(
  parameter int ENTRIES     = 2048,
  parameter int ROOT_INDEX  = 0,
  parameter int TABLE_INDEX = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fca_pkg::OP_W-1:0]    op_i,
  input  logic [fca_pkg::BLK_W-1:0]   block_i,
  input  logic [fca_pkg::LEN_W-1:0]   amount_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fca_pkg::STAT_W-1:0]  status_o,
  output logic [fca_pkg::BLK_W-1:0]   first_block_o,
  output logic [fca_pkg::LEN_W-1:0]   length_o,
  output logic [fca_pkg::KIND_W-1:0]  entry_kind_o
);
  import fca_pkg::*;

  localparam int AW = $clog2(ENTRIES);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  logic             res_valid;
  logic             res_ready;
  res_t             res;

  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  // table storage
  fca_mem #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer
  fca_ctrl #(
    .ENTRIES     (ENTRIES),
    .ROOT_INDEX  (ROOT_INDEX),
    .TABLE_INDEX (TABLE_INDEX),
    .AW          (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .op_i        (op_i),
    .block_i     (block_i),
    .amount_i    (amount_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // output register: loads when empty or when its beat leaves
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign first_block_o = out_q.first_block;
  assign length_o      = out_q.length;
  assign entry_kind_o  = out_q.kind;

endmodule

// File: rtl/fca_chk.sv
// ---------------------------------------------------------------------------
// fca_chk
// Port checks for the chain allocator, bound to the top level.
// ---------------------------------------------------------------------------
module fca_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [fca_pkg::STAT_W-1:0]  status_o,
  input logic [fca_pkg::BLK_W-1:0]   first_block_o,
  input logic [fca_pkg::LEN_W-1:0]   length_o,
  input logic [fca_pkg::KIND_W-1:0]  entry_kind_o
);
  import fca_pkg::*;

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pending_q, pending_d;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // requests taken whose result beat has not yet left
  always_comb begin
    pending_d = pending_q;
    if (in_beat && !out_beat) begin
      pending_d = pending_q + 2'd1;
    end else if (out_beat && !in_beat) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(first_block_o) && $stable(length_o) && $stable(entry_kind_o))
    else $error("result beat changed under stall");

  // no result without a request behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> pending_q != 2'd0)
    else $error("result beat with no request outstanding");

  // one request at work and one result held at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many requests outstanding");

  // failures carry no block or length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> (length_o == '0) &&
      (first_block_o == '0) && (entry_kind_o == KIND_INDEX))
    else $error("failed result carries payload");

  // an entry kind only comes from a read, which has no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (entry_kind_o != KIND_INDEX) |-> (length_o == '0) &&
      (status_o == STAT_OK) && (first_block_o == '0))
    else $error("entry kind on a non-read result");

endmodule

bind fat_chain_allocator fca_chk u_fca_chk (.*);
